>>> rtl/wpca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpca_pkg
// Shared codes, widths and sequencer states of the port credit allocator.
// ----------------------------------------------------------------------------
package wpca_pkg;

	localparam int OpW     = 2;
	localparam int PortW   = 3;
	localparam int SizeW   = 16;
	localparam int WeightW = 16;
	localparam int CreditW = 32;
	localparam int PeriodW = 31;
	localparam int WsumW   = 19;
	localparam int StepW   = 5;

	localparam logic [CreditW-1:0] CREDIT_UNLIMITED = '1;

	typedef enum logic [OpW-1:0] {
		OP_PAY  = 2'd0,
		OP_TICK = 2'd1,
		OP_JOIN = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_EXEC = 12'b0000_0000_0010,
		S_MUL  = 12'b0000_0000_0100,
		S_LD   = 12'b0000_0000_1000,
		S_DIV  = 12'b0000_0001_0000,
		S_QUO  = 12'b0000_0010_0000,
		S_ADD  = 12'b0000_0100_0000,
		S_LO   = 12'b0000_1000_0000,
		S_HI   = 12'b0001_0000_0000,
		S_CMP  = 12'b0010_0000_0000,
		S_MOVE = 12'b0100_0000_0000,
		S_EMIT = 12'b1000_0000_0000
	} state_t;

endpackage

>>> rtl/weighted_port_credit_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_port_credit_allocator
// Per-port packet credit store with weighted periodic refill.
// ----------------------------------------------------------------------------
// A pay or join item is latched in the idle state and its single result is
// loaded into the output register from the execute state once that register
// is free. A tick walks the listed ports in order, one port at a time,
// through one shared 32x32 multiplier and one shared restoring divider that
// retires one quotient bit per cycle. Each port runs a multiply, a load, 32
// divide steps and a quotient step, then add, clamp or compare, list move and
// result; when a port's surplus is redistributed, a second multiply and
// divide run. The input is stalled while an item is being worked on; the
// next item may be taken while the last result still waits at the output.
// The period credit register is written through its own valid/ready port,
// which is always ready; write it only while idle.
// ----------------------------------------------------------------------------
module weighted_port_credit_allocator #(
	parameter int PORTS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wpca_pkg::PeriodW-1:0]  period_credit,
	// input items
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [wpca_pkg::OpW-1:0]      operation,
	input  logic [wpca_pkg::PortW-1:0]    port,
	input  logic [wpca_pkg::SizeW-1:0]    packet_size,
	input  logic [wpca_pkg::WeightW-1:0]  port_weight,
	input  logic [wpca_pkg::CreditW-1:0]  floor_credit,
	input  logic [wpca_pkg::CreditW-1:0]  ceiling_credit,
	input  logic [wpca_pkg::CreditW-1:0]  start_credit,
	// result items
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [wpca_pkg::PortW-1:0]    out_port,
	output logic                          pay_ok,
	output logic [wpca_pkg::CreditW-1:0]  credit,
	output logic                          last
);
	import wpca_pkg::*;

	localparam int IW = (PORTS > 1) ? $clog2(PORTS) : 1;
	localparam int CW = $clog2(PORTS + 1);

	state_t state_q;

	// per-port state, cleared by reset
	logic [CreditW-1:0] remaining_q [PORTS];
	logic [WeightW-1:0] weights_q   [PORTS];
	logic [CreditW-1:0] floors_q    [PORTS];
	logic [CreditW-1:0] ceilings_q  [PORTS];
	logic [CW-1:0]      count_q;
	logic [WsumW-1:0]   wsum_q;
	logic [CreditW-1:0] carried_q;
	logic [PeriodW-1:0] period_q;
	logic               out_valid_q;

	// visiting order, only the first count_q entries are meaningful
	logic [IW-1:0]      order_q [PORTS];
	logic [IW-1:0]      visit_q [PORTS];

	// latched item
	logic [OpW-1:0]     op_q;
	logic [PortW-1:0]   port_q;
	logic [SizeW-1:0]   size_q;
	logic [WeightW-1:0] wt_q;
	logic [CreditW-1:0] flo_q;
	logic [CreditW-1:0] cei_q;
	logic [CreditW-1:0] start_q;

	// tick working registers
	logic [IW-1:0]      idx_q;
	logic [CreditW-1:0] pool_q;
	logic [CreditW-1:0] total_q;
	logic [CreditW-1:0] wleft_q;
	logic [CreditW-1:0] left_q;
	logic [CreditW-1:0] fair_q;
	logic [CreditW-1:0] cur_q;
	logic               extra_q;
	logic               move_q;
	logic               spill_q;

	// shared multiply / divide unit
	logic [CreditW-1:0] prod_q;
	logic [CreditW-1:0] dnum_q;
	logic [CreditW-1:0] drem_q;
	logic [CreditW-1:0] dden_q;
	logic [StepW-1:0]   dcnt_q;

	// output register payload
	logic [PortW-1:0]   oport_q;
	logic               ook_q;
	logic [CreditW-1:0] ocredit_q;
	logic               olast_q;

	logic               out_free;
	logic               out_load;
	logic               port_in;
	logic [IW-1:0]      ax;
	logic [WeightW-1:0] w_rd;
	logic [CreditW-1:0] rem_rd;
	logic [CreditW-1:0] flo_rd;
	logic [CreditW-1:0] cei_rd;
	logic               hit;
	logic [IW-1:0]      pos;
	logic [IW-1:0]      head [PORTS];
	logic [CreditW-1:0] mul_a;
	logic [CreditW-1:0] mul_b;
	logic [CreditW-1:0] mul_p;
	logic [CreditW-1:0] den;
	logic [CreditW:0]   trial;
	logic [CreditW-1:0] quo;
	logic               pay_fit;
	logic               is_last;
	logic [CreditW-1:0] period_x;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	// load a result into the output register this cycle
	assign out_load  = out_free && (state_q == S_EXEC || state_q == S_EMIT);
	assign port_in   = (32'(port_q) < PORTS);
	assign period_x  = {1'b0, period_q};

	// one array address: the item's port while executing, else the visited port
	assign ax     = (state_q == S_EXEC) ? IW'(port_q) : visit_q[idx_q];
	assign w_rd   = weights_q[ax];
	assign rem_rd = remaining_q[ax];
	assign flo_rd = floors_q[ax];
	assign cei_rd = ceilings_q[ax];

	assign pay_fit = (rem_rd != CREDIT_UNLIMITED) && (rem_rd >= 32'(size_q));
	assign is_last = (CW'(idx_q) == count_q - CW'(1));

	// locate the port in the list and build the list with it moved to the head
	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = 0; i < PORTS; i++) begin
			if (!hit && (order_q[i] == ax) && (CW'(i) < count_q)) begin
				hit = 1'b1;
				pos = IW'(i);
			end
		end
		for (int i = 0; i < PORTS; i++) begin
			if (i == 0)
				head[i] = order_q[pos];
			else if (IW'(i) <= pos)
				head[i] = order_q[i-1];
			else
				head[i] = order_q[i];
		end
	end

	// shared unit operands: share of the pool, or redistribution of the surplus
	assign mul_a = spill_q ? left_q  : pool_q;
	assign mul_b = spill_q ? total_q : 32'(w_rd);
	assign mul_p = mul_a * mul_b;
	assign den   = spill_q ? wleft_q : total_q;
	assign trial = {drem_q, dnum_q[CreditW-1]} - {1'b0, dden_q};
	assign quo   = (dden_q == '0) ? '0 : dnum_q;

	// control and stored state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			wsum_q      <= '0;
			carried_q   <= '0;
			period_q    <= PeriodW'(65536);
			for (int i = 0; i < PORTS; i++) begin
				remaining_q[i] <= '0;
				weights_q[i]   <= '0;
				floors_q[i]    <= '0;
				ceilings_q[i]  <= '0;
			end
		end else begin
			if (cfg_valid)
				period_q <= period_credit;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (operation)
							OP_TICK: begin
								if (count_q != '0 && wsum_q != '0)
									state_q <= S_MUL;
							end
							OP_PAY, OP_JOIN: state_q <= S_EXEC;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (port_in && op_q == OP_PAY && pay_fit)
							remaining_q[ax] <= rem_rd - 32'(size_q);
						if (port_in && op_q == OP_JOIN) begin
							if (hit) begin
								wsum_q <= wsum_q - WsumW'(w_rd) + WsumW'(wt_q);
							end else begin
								if (count_q < CW'(PORTS))
									count_q <= count_q + CW'(1);
								wsum_q <= wsum_q + WsumW'(wt_q);
							end
							weights_q[ax]   <= wt_q;
							floors_q[ax]    <= flo_q;
							ceilings_q[ax]  <= cei_q;
							remaining_q[ax] <= start_q;
						end
					end
				end
				S_MUL: state_q <= S_LD;
				S_LD:  state_q <= S_DIV;
				S_DIV: begin
					if (dcnt_q == '1)
						state_q <= S_QUO;
				end
				S_QUO: state_q <= spill_q ? S_MOVE : S_ADD;
				S_ADD: begin
					if (flo_rd != '0 || cei_rd != '0)
						state_q <= S_LO;
					else
						state_q <= S_CMP;
				end
				S_LO: state_q <= S_HI;
				S_HI: state_q <= S_MOVE;
				S_CMP: begin
					if (cur_q < period_x)
						state_q <= S_EMIT;
					else if (wleft_q != '0)
						state_q <= S_MUL;
					else
						state_q <= S_MOVE;
				end
				S_MOVE: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						remaining_q[ax] <= cur_q;
						if (is_last) begin
							carried_q <= left_q;
							state_q   <= S_IDLE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q    <= operation;
					port_q  <= port;
					size_q  <= packet_size;
					wt_q    <= port_weight;
					flo_q   <= floor_credit;
					cei_q   <= ceiling_credit;
					start_q <= start_credit;
					// prime the tick walk
					total_q <= CreditW'(wsum_q);
					wleft_q <= CreditW'(wsum_q);
					pool_q  <= period_x + carried_q;
					left_q  <= '0;
					extra_q <= 1'b0;
					spill_q <= 1'b0;
					idx_q   <= '0;
					visit_q <= order_q;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					oport_q <= port_q;
					olast_q <= 1'b1;
					if (!port_in) begin
						ook_q     <= 1'b0;
						ocredit_q <= '0;
					end else if (op_q == OP_PAY) begin
						ook_q     <= (rem_rd == CREDIT_UNLIMITED) || pay_fit;
						ocredit_q <= pay_fit ? rem_rd - 32'(size_q) : rem_rd;
					end else begin
						ook_q     <= 1'b1;
						ocredit_q <= start_q;
					end
					if (port_in && op_q == OP_JOIN && !hit && count_q < CW'(PORTS))
						order_q[count_q[IW-1:0]] <= IW'(port_q);
				end
			end
			S_MUL: begin
				prod_q <= mul_p;
				if (!spill_q)
					wleft_q <= wleft_q - 32'(w_rd);
			end
			S_LD: begin
				dnum_q <= prod_q + den - 32'd1;
				drem_q <= '0;
				dden_q <= den;
				dcnt_q <= '0;
			end
			S_DIV: begin
				if (!trial[CreditW])
					drem_q <= trial[CreditW-1:0];
				else
					drem_q <= {drem_q[CreditW-2:0], dnum_q[CreditW-1]};
				dnum_q <= {dnum_q[CreditW-2:0], !trial[CreditW]};
				dcnt_q <= dcnt_q + StepW'(1);
			end
			S_QUO: begin
				if (spill_q) begin
					pool_q <= pool_q + quo;
					left_q <= '0;
				end else begin
					fair_q <= quo;
				end
			end
			S_ADD: begin
				cur_q  <= rem_rd + fair_q;
				move_q <= 1'b0;
			end
			S_LO: begin
				// raise to the floor and take the difference from the pool
				if (flo_rd != '0 && cur_q < flo_rd) begin
					pool_q  <= pool_q - (flo_rd - cur_q);
					cur_q   <= flo_rd;
					total_q <= total_q - 32'(w_rd);
					move_q  <= 1'b1;
				end
			end
			S_HI: begin
				// cut to the ceiling and return the excess to the pool
				if (cei_rd != '0 && cur_q > cei_rd) begin
					pool_q  <= pool_q + (cur_q - cei_rd);
					cur_q   <= cei_rd;
					total_q <= total_q - 32'(w_rd);
					move_q  <= 1'b1;
				end
			end
			S_CMP: begin
				if (cur_q < period_x) begin
					extra_q <= 1'b1;
				end else begin
					left_q  <= left_q + (cur_q - fair_q);
					cur_q   <= (count_q > CW'(1)) ? fair_q : period_x;
					move_q  <= extra_q;
					spill_q <= (wleft_q != '0);
				end
			end
			S_MOVE: begin
				if (move_q)
					order_q <= head;
			end
			S_EMIT: begin
				if (out_free) begin
					oport_q   <= PortW'(ax);
					ook_q     <= 1'b1;
					ocredit_q <= cur_q;
					olast_q   <= is_last;
					idx_q     <= idx_q + IW'(1);
					spill_q   <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_port  = oport_q;
	assign pay_ok    = ook_q;
	assign credit    = ocredit_q;
	assign last      = olast_q;

endmodule

>>> rtl/wpca_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpca_check
// Port-level checks of the credit allocator, bound to the top level.
// ----------------------------------------------------------------------------
module wpca_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [wpca_pkg::OpW-1:0]     operation,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [wpca_pkg::PortW-1:0]   out_port,
	input logic                         pay_ok,
	input logic [wpca_pkg::CreditW-1:0] credit,
	input logic                         last
);
	import wpca_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(credit) && $stable(out_port)
			&& $stable(pay_ok) && $stable(last))
		else $error("stalled result changed");

	a_pay_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == OP_PAY |=> in_stall)
		else $error("pay item not held off the input");

	a_refuse_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pay_ok |-> last)
		else $error("refused result is not a single result");

endmodule

bind weighted_port_credit_allocator wpca_check u_wpca_check (.*);
